### rtl/first_order_lag_heun_step_assert.svh
// Assertion macros for the first-order lag Heun step block.
`ifndef FIRST_ORDER_LAG_HEUN_STEP_ASSERT_SVH
`define FIRST_ORDER_LAG_HEUN_STEP_ASSERT_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define FLHS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// antecedent implies consequent in the next cycle
`define FLHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define FLHS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FLHS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/flhs_pkg.sv
// Shared types and constants for the first-order lag Heun step block.
package flhs_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned Q_SHIFT = 16;
  localparam int unsigned DIFF_W  = DATA_W + 1;
  localparam int unsigned NUM_W   = DIFF_W + Q_SHIFT;
  localparam int unsigned CNT_W   = $clog2(NUM_W);

  localparam logic [DATA_W-1:0] S32_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] TC_RESET = 32'd0;
  localparam logic [DATA_W-1:0] TS_RESET = 32'd655;

  // configuration register indexes
  localparam logic CFG_TC = 1'b0;
  localparam logic CFG_TS = 1'b1;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_PRED = 2'd1,
    KIND_CORR = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] diff;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

### rtl/first_order_lag_heun_step.sv
// Top level: first-order lag integrated with a predictor-corrector step.
//
// Input channel (in_valid/in_ready): one beat carries kind, sample and
// first_pass. Output channel (out_valid/out_ready): one result beat per
// input beat, in order. Config port: cfg_we writes cfg_data into register
// cfg_index (0 time constant, 1 time step), no wait states.
//
// Sequencing: a beat is accepted in idle and goes to preparation. Predictor
// and corrector beats that run the slope then wait on the bit-serial divider,
// then multiply, add and finish; bypassed predictor/corrector beats skip the
// divider, and initialise and the unused kind go from preparation straight to
// finish. One beat is in flight at a time; in_ready is low while it is worked
// on.
//
// Reset clears the sequencer, out_valid and the integrator state; the time
// constant resets to 0 and the time step to 655. A stalled receiver holds
// the result in the output register; the block waits in the finish state,
// with in_ready low, until the register frees.
module first_order_lag_heun_step
  import flhs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     first_pass,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  `include "first_order_lag_heun_step_assert.svh"

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ADD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [DATA_W-1:0] tc;
  logic [DATA_W-1:0] ts;

  // integrator state
  logic signed [DATA_W-1:0] start_state;
  logic signed [DATA_W-1:0] end_state;
  logic signed [DATA_W-1:0] start_slope;

  // working registers for the beat in flight
  kind_t                    k;
  logic signed [DATA_W-1:0] smp;
  logic signed [DATA_W-1:0] res_hold;
  logic signed [DATA_W-1:0] mslope;
  logic signed [63:0]       prod;

  logic                     bypass;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [DATA_W:0]   avg_sum;
  logic signed [DATA_W:0]   half_slope;
  logic signed [64:0]       prod_full;
  logic signed [48:0]       adv_sum;
  logic signed [DATA_W-1:0] adv_sat;

  assign in_ready = (state == S_IDLE);

  // divider is bypassed when tc is zero or under four steps (exact compare)
  assign bypass = (tc == '0) || ({2'b00, tc} < {ts, 2'b00});

  assign div_req.start = (state == S_PREP) && !bypass &&
                         ((k == KIND_PRED) || (k == KIND_CORR));
  assign div_req.diff  = (k == KIND_PRED)
                         ? {smp[DATA_W-1], smp} - {start_state[DATA_W-1], start_state}
                         : {smp[DATA_W-1], smp} - {end_state[DATA_W-1], end_state};

  flhs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .den (tc),
    .rsp (div_rsp)
  );

  // floor of the slope average, and floor of start_slope / 2 for bypass
  assign avg_sum    = {start_slope[DATA_W-1], start_slope} +
                      {div_rsp.quo[DATA_W-1], div_rsp.quo};
  assign half_slope = {start_slope[DATA_W-1], start_slope} >>> 1;

  // slope * time_step, exact; the floor shift is the top 48 bits
  assign prod_full = mslope * $signed({1'b0, ts});

  assign adv_sum = {{17{start_state[DATA_W-1]}}, start_state} +
                   {prod[63], prod[63:Q_SHIFT]};

  always_comb begin
    if (adv_sum > 49'sh0_7FFF_FFFF)       adv_sat = $signed(S32_MAX);
    else if (adv_sum < -49'sh0_8000_0000) adv_sat = $signed(S32_MIN);
    else                                  adv_sat = adv_sum[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      tc          <= TC_RESET;
      ts          <= TS_RESET;
      start_state <= '0;
      end_state   <= '0;
      start_slope <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TC:  tc <= cfg_data;
          CFG_TS:  ts <= cfg_data;
          default: ;
        endcase
      end

      // output register: load a finished beat, else drop it once taken
      if ((state == S_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            k   <= kind_t'(kind);
            smp <= sample;
            // commit last step's end as the new start
            if ((kind_t'(kind) == KIND_PRED) && !first_pass) start_state <= end_state;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          case (k)
            KIND_INIT: begin
              start_state <= smp;
              end_state   <= smp;
              start_slope <= '0;
              res_hold    <= smp;
              state       <= S_FIN;
            end
            KIND_PRED: begin
              if (bypass) begin
                start_slope <= '0;
                start_state <= smp;
                mslope      <= '0;
                res_hold    <= smp;
                state       <= S_MUL;
              end else begin
                res_hold <= start_state;
                state    <= S_DIV;
              end
            end
            KIND_CORR: begin
              if (bypass) begin
                end_state <= smp;
                mslope    <= half_slope[DATA_W-1:0];
                res_hold  <= smp;
                state     <= S_MUL;
              end else begin
                res_hold <= end_state;
                state    <= S_DIV;
              end
            end
            default: begin
              res_hold <= end_state;
              state    <= S_FIN;
            end
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (k == KIND_PRED) begin
              start_slope <= div_rsp.quo;
              mslope      <= div_rsp.quo;
            end else begin
              mslope <= avg_sum[DATA_W:1];
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_full[63:0];
          state <= S_ADD;
        end
        S_ADD: begin
          end_state <= adv_sat;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            result <= res_hold;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider finishes only while the sequencer waits on it
  `FLHS_ASSERT_IMP(a_div_done_in_div, clk, rst, div_rsp.done, state == S_DIV)
  // an accepted beat always moves to preparation
  `FLHS_ASSERT_NEXT(a_accept_to_prep, clk, rst, in_valid && in_ready, state == S_PREP)
  // a finished beat lands in the output register with the held result
  `FLHS_ASSERT_NEXT(a_fin_loads_out, clk, rst,
    (state == S_FIN) && (!out_valid || out_ready),
    out_valid && (result == $past(res_hold)) && (state == S_IDLE))

endmodule

### rtl/flhs_div.sv
// Bit-serial restoring divider: sat32((diff << 16) / den), truncated toward zero.
module flhs_div
  import flhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [DATA_W-1:0] den,
  output div_rsp_t          rsp
);

  logic              busy;
  logic              done;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  numr;
  logic [NUM_W-1:0]  quo;
  logic [DATA_W-1:0] rem;

  logic [DIFF_W-1:0] mag;
  logic [DATA_W:0]   rsh;
  logic [DATA_W+1:0] trial;

  assign mag   = req.diff[DIFF_W-1] ? DIFF_W'(-req.diff) : DIFF_W'(req.diff);
  assign rsh   = {rem, numr[NUM_W-1]};
  assign trial = {1'b0, rsh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        neg  <= req.diff[DIFF_W-1];
        numr <= {mag, {Q_SHIFT{1'b0}}};
        quo  <= '0;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        numr <= {numr[NUM_W-2:0], 1'b0};
        if (!trial[DATA_W+1]) begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rsh[DATA_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate the magnitude back into signed 32 bits
  always_comb begin
    rsp.done = done;
    if (neg) begin
      if (quo > NUM_W'(S32_MIN)) rsp.quo = S32_MIN;
      else                       rsp.quo = -$signed(quo[DATA_W-1:0]);
    end else begin
      if (quo > NUM_W'(S32_MAX)) rsp.quo = S32_MAX;
      else                       rsp.quo = $signed(quo[DATA_W-1:0]);
    end
  end

endmodule
